// ===== src/line_rotate_project_3d_unit_defines.svh =====
// Assertion macros shared by the line rotate and project block.
// Uses no package; the including module must provide clk and arst_n.
`ifndef LINE_ROTATE_PROJECT_3D_UNIT_DEFINES_SVH
`define LINE_ROTATE_PROJECT_3D_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRP3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRP3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lrp3_pkg.sv =====
// Shared types, widths, the sine table and arithmetic helpers of the
// line rotate and project block. Depends on nothing.
package lrp3_pkg;

	localparam int COORD_W    = 12;
	localparam int ANGLE_W    = 9;
	localparam int FRAC_BITS  = 14;
	localparam int TRIG_W     = FRAC_BITS + 2;
	localparam int PROD_W     = COORD_W + TRIG_W;
	localparam int DOT_W      = PROD_W + 2;
	localparam int RV_W       = 14;
	localparam int PROJ_SHIFT = 8;
	localparam int NUM_W      = RV_W - 1 + PROJ_SHIFT;
	localparam int DEN_W      = 14;
	localparam int DEPTH_W    = 15;
	localparam int DIV_BITS   = 3;
	localparam int DIV_STAGES = NUM_W / DIV_BITS;
	localparam int SCR_W      = 16;
	localparam int XOFF_W     = 10;
	localparam int YOFF_W     = 10;
	localparam int DOFF_W     = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int RES_W      = NUM_W + 2;
	localparam int NEAR_LIMIT = -5;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 2'd2;

	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [RV_W-1:0]    rv_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] work;
	} div_state_t;

	localparam logic [14:0] SIN_TAB [0:90] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
		15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
		15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
		15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
		15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
		15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
		15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
		15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
		15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
		15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
		15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16224, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
	};

	// Reduces a raw 9-bit angle to 0..359.
	function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W-1:0] a);
		return (a >= 9'd360) ? a - 9'd360 : a;
	endfunction

	// Sine of a whole-degree angle in 0..359, with FRAC_BITS fraction bits.
	function automatic trig_t sin_deg(input logic [ANGLE_W-1:0] a);
		logic [6:0]   idx;
		logic         neg;
		trig_t        mag;
		if (a <= 9'd90) begin
			idx = a[6:0];
			neg = 1'b0;
		end else if (a <= 9'd180) begin
			idx = 7'(9'd180 - a);
			neg = 1'b0;
		end else if (a <= 9'd270) begin
			idx = 7'(a - 9'd180);
			neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - a);
			neg = 1'b1;
		end
		mag = trig_t'({1'b0, SIN_TAB[idx]});
		return neg ? -mag : mag;
	endfunction

	function automatic trig_t cos_deg(input logic [ANGLE_W-1:0] a);
		logic [ANGLE_W:0] b;
		b = {1'b0, a} + 10'd90;
		if (b >= 10'd360) begin
			b = b - 10'd360;
		end
		return sin_deg(b[ANGLE_W-1:0]);
	endfunction

	// Product of two trig values, truncated toward zero to FRAC_BITS fraction bits.
	function automatic trig_t trig_mul(input trig_t a, input trig_t b);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b;
		if (p < 0) begin
			p = p + ((2*TRIG_W)'(1) <<< FRAC_BITS) - (2*TRIG_W)'(1);
		end
		return trig_t'(p >>> FRAC_BITS);
	endfunction

endpackage

// ===== src/lrp3_if.sv =====
// Valid/ready channel interfaces for segment input and projected output.
// Depends on lrp3_pkg.
interface lrp3_in_if;
	import lrp3_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ANGLE_W-1:0]   x_angle;
	logic [ANGLE_W-1:0]   y_angle;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] start_z;
	logic signed [COORD_W-1:0] end_x;
	logic signed [COORD_W-1:0] end_y;
	logic signed [COORD_W-1:0] end_z;
	modport source (output valid, x_angle, y_angle, start_x, start_y, start_z,
		end_x, end_y, end_z, input ready);
	modport sink (input valid, x_angle, y_angle, start_x, start_y, start_z,
		end_x, end_y, end_z, output ready);
endinterface

interface lrp3_out_if;
	import lrp3_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SCR_W-1:0] screen_start_x;
	logic signed [SCR_W-1:0] screen_start_y;
	logic signed [SCR_W-1:0] screen_end_x;
	logic signed [SCR_W-1:0] screen_end_y;
	logic                    line_valid;
	modport source (output valid, screen_start_x, screen_start_y, screen_end_x,
		screen_end_y, line_valid, input ready);
	modport sink (input valid, screen_start_x, screen_start_y, screen_end_x,
		screen_end_y, line_valid, output ready);
endinterface

// ===== src/lrp3_div.sv =====
// Pipelined unsigned restoring divider, a few quotient bits per stage.
// Depends on lrp3_pkg.
module lrp3_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [lrp3_pkg::NUM_W-1:0] num,
	input  logic [lrp3_pkg::DEN_W-1:0] den,
	output logic [lrp3_pkg::NUM_W-1:0] quo
);
	import lrp3_pkg::*;

	div_state_t       st_q  [0:DIV_STAGES];
	logic [DEN_W-1:0] den_q [0:DIV_STAGES];

	always_comb begin
		st_q[0]  = '{rem: '0, work: num};
		den_q[0] = den;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		div_state_t     nxt;
		logic [DEN_W:0] r;

		always_comb begin
			nxt = st_q[k];
			r   = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				r = {nxt.rem, nxt.work[NUM_W-1]};
				nxt.work = nxt.work << 1;
				if (r >= {1'b0, den_q[k]}) begin
					r = r - {1'b0, den_q[k]};
					nxt.work[0] = 1'b1;
				end
				nxt.rem = r[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[k+1]  <= nxt;
				den_q[k+1] <= den_q[k];
			end
		end
	end

	assign quo = st_q[DIV_STAGES].work;

endmodule

// ===== src/line_rotate_project_3d_unit.sv =====
// Top level of the line rotate and project block: rotation, depth test,
// perspective divide and saturation. Depends on lrp3_pkg, lrp3_if, lrp3_div
// and line_rotate_project_3d_unit_defines.svh.
//
//  channel   | dir | transaction
//  ----------+-----+-------------------------------------------------------
//  in_ch     | in  | one segment: two angles, two endpoints (valid/ready)
//  out_ch    | out | two screen points and line_valid (valid/ready)
//  cfg_*     | in  | register write: cfg_wr_en, cfg_idx, cfg_wdata
//
// A transaction enters every cycle unless the output stalls, and its result
// passes five arithmetic stages, seven divider stages of three quotient bits
// each, and the output register; the divider is most of that depth.
// arst_n clears all valid bits and loads the register reset values.
// When the output register holds an untaken result the whole pipeline
// freezes together, so nothing is lost or repeated during a stall.
`include "line_rotate_project_3d_unit_defines.svh"

module line_rotate_project_3d_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lrp3_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lrp3_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lrp3_in_if.sink                         in_ch,
	lrp3_out_if.source                      out_ch
);
	import lrp3_pkg::*;

	// Configuration registers.
	logic [XOFF_W-1:0] x_off_q;
	logic [YOFF_W-1:0] y_off_q;
	logic [DOFF_W-1:0] d_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= XOFF_W'(63);
			y_off_q <= YOFF_W'(63);
			d_off_q <= DOFF_W'(500);
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_SCREEN_X: x_off_q <= cfg_wdata[XOFF_W-1:0];
				REG_SCREEN_Y: y_off_q <= cfg_wdata[YOFF_W-1:0];
				REG_DEPTH:    d_off_q <= cfg_wdata[DOFF_W-1:0];
				default: ;
			endcase
		end
	end

	// One enable advances every stage; it drops only when a result waits.
	logic adv;
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: wrap the angles and look up sine and cosine.
	trig_t  sy_s1, cy_s1, sx_s1, cx_s1;
	coord_t pa_s1 [0:2];
	coord_t pb_s1 [0:2];
	logic [ANGLE_W-1:0] xa_w, ya_w;

	assign xa_w = wrap_angle(in_ch.x_angle);
	assign ya_w = wrap_angle(in_ch.y_angle);

	always_ff @(posedge clk) begin
		if (adv) begin
			sy_s1    <= sin_deg(ya_w);
			cy_s1    <= cos_deg(ya_w);
			sx_s1    <= sin_deg(xa_w);
			cx_s1    <= cos_deg(xa_w);
			pa_s1[0] <= in_ch.start_x;
			pa_s1[1] <= in_ch.start_y;
			pa_s1[2] <= in_ch.start_z;
			pb_s1[0] <= in_ch.end_x;
			pb_s1[1] <= in_ch.end_y;
			pb_s1[2] <= in_ch.end_z;
		end
	end

	// Stage 2: build the rotation matrix Rx * Ry, row by row.
	trig_t  m_s2  [0:8];
	coord_t pa_s2 [0:2];
	coord_t pb_s2 [0:2];

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0] <= cy_s1;
			m_s2[1] <= '0;
			m_s2[2] <= -sy_s1;
			m_s2[3] <= trig_mul(sy_s1, sx_s1);
			m_s2[4] <= cx_s1;
			m_s2[5] <= trig_mul(cy_s1, sx_s1);
			m_s2[6] <= trig_mul(sy_s1, cx_s1);
			m_s2[7] <= -sx_s1;
			m_s2[8] <= trig_mul(cy_s1, cx_s1);
			pa_s2   <= pa_s1;
			pb_s2   <= pb_s1;
		end
	end

	// Stage 3: all nine products for each endpoint.
	prod_t pra_s3 [0:8];
	prod_t prb_s3 [0:8];

	for (genvar i = 0; i < 9; i++) begin : g_prod
		always_ff @(posedge clk) begin
			if (adv) begin
				pra_s3[i] <= PROD_W'(pa_s2[i % 3]) * PROD_W'(m_s2[i]);
				prb_s3[i] <= PROD_W'(pb_s2[i % 3]) * PROD_W'(m_s2[i]);
			end
		end
	end

	// Stage 4: dot products, truncated toward zero to whole units.
	rv_t rva_s4 [0:2];
	rv_t rvb_s4 [0:2];

	function automatic rv_t dot_trunc(input prod_t p0, input prod_t p1, input prod_t p2);
		logic signed [DOT_W-1:0] s;
		s = DOT_W'(p0) + DOT_W'(p1) + DOT_W'(p2);
		if (s < 0) begin
			s = s + ((DOT_W'(1) <<< FRAC_BITS) - DOT_W'(1));
		end
		return rv_t'(s >>> FRAC_BITS);
	endfunction

	for (genvar r = 0; r < 3; r++) begin : g_row
		always_ff @(posedge clk) begin
			if (adv) begin
				rva_s4[r] <= dot_trunc(pra_s3[3*r], pra_s3[3*r+1], pra_s3[3*r+2]);
				rvb_s4[r] <= dot_trunc(prb_s3[3*r], prb_s3[3*r+1], prb_s3[3*r+2]);
			end
		end
	end

	// Stage 5: depth test and sign/magnitude split for the divider.
	// Lanes: 0 start x, 1 start y, 2 end x, 3 end y.
	logic signed [DEPTH_W-1:0] da_w, db_w;
	logic [NUM_W-1:0] num_s5 [0:3];
	logic [DEN_W-1:0] dena_s5, denb_s5;
	logic [3:0]       neg_s5;
	logic             ok_s5;

	assign da_w = DEPTH_W'(rva_s4[2]) - DEPTH_W'($signed({1'b0, d_off_q}));
	assign db_w = DEPTH_W'(rvb_s4[2]) - DEPTH_W'($signed({1'b0, d_off_q}));

	function automatic logic [NUM_W-1:0] scaled_mag(input rv_t v);
		rv_t a;
		a = (v < 0) ? -v : v;
		return {a[RV_W-2:0], {PROJ_SHIFT{1'b0}}};
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5[0] <= scaled_mag(rva_s4[0]);
			num_s5[1] <= scaled_mag(rva_s4[1]);
			num_s5[2] <= scaled_mag(rvb_s4[0]);
			num_s5[3] <= scaled_mag(rvb_s4[1]);
			// Depth is negative whenever it is used, so the quotient sign is
			// the opposite of the numerator sign.
			neg_s5    <= {!rvb_s4[1][RV_W-1], !rvb_s4[0][RV_W-1],
				!rva_s4[1][RV_W-1], !rva_s4[0][RV_W-1]};
			dena_s5   <= DEN_W'(-da_w);
			denb_s5   <= DEN_W'(-db_w);
			ok_s5     <= (da_w < DEPTH_W'(NEAR_LIMIT)) && (db_w < DEPTH_W'(NEAR_LIMIT));
		end
	end

	// Divider lanes and the side data that travels beside them.
	logic [NUM_W-1:0] quo [0:3];

	for (genvar l = 0; l < 4; l++) begin : g_div
		lrp3_div u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s5[l]),
			.den ((l < 2) ? dena_s5 : denb_s5),
			.quo (quo[l])
		);
	end

	logic       v_d_q   [1:DIV_STAGES];
	logic       ok_d_q  [1:DIV_STAGES];
	logic [3:0] neg_d_q [1:DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STAGES; k++) begin
				v_d_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_d_q[1] <= v_s5;
			for (int k = 2; k <= DIV_STAGES; k++) begin
				v_d_q[k] <= v_d_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_d_q[1]  <= ok_s5;
			neg_d_q[1] <= neg_s5;
			for (int k = 2; k <= DIV_STAGES; k++) begin
				ok_d_q[k]  <= ok_d_q[k-1];
				neg_d_q[k] <= neg_d_q[k-1];
			end
		end
	end

	// Output stage: sign, screen offset, saturation, invalid-line zeroing.
	function automatic logic signed [SCR_W-1:0] finish(input logic [NUM_W-1:0] q,
		input logic neg, input logic [XOFF_W-1:0] off);
		logic signed [RES_W-1:0] s;
		s = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
		s = s + RES_W'($signed({1'b0, off}));
		if (s > RES_W'(32767)) begin
			return SCR_W'(32767);
		end else if (s < -RES_W'(32768)) begin
			return SCR_W'(-32768);
		end
		return SCR_W'(s);
	endfunction

	logic line_ok;
	assign line_ok = ok_d_q[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= v_d_q[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.line_valid     <= line_ok;
			out_ch.screen_start_x <= line_ok ? finish(quo[0], neg_d_q[DIV_STAGES][0],
				x_off_q) : '0;
			out_ch.screen_start_y <= line_ok ? finish(quo[1], neg_d_q[DIV_STAGES][1],
				y_off_q) : '0;
			out_ch.screen_end_x   <= line_ok ? finish(quo[2], neg_d_q[DIV_STAGES][2],
				x_off_q) : '0;
			out_ch.screen_end_y   <= line_ok ? finish(quo[3], neg_d_q[DIV_STAGES][3],
				y_off_q) : '0;
		end
	end

	// A rejected line must carry all-zero coordinates.
	`LRP3_ASSERT_NOW(a_reject_zero, out_ch.valid && !out_ch.line_valid,
		out_ch.screen_start_x == 0 && out_ch.screen_start_y == 0 &&
		out_ch.screen_end_x == 0 && out_ch.screen_end_y == 0,
		"rejected line has nonzero coordinates")
	// An accepted transaction always lands in the first stage.
	`LRP3_ASSERT_NEXT(a_enter_s1, in_ch.valid && in_ch.ready, v_s1,
		"accepted transaction missing from stage 1")
	// A frozen pipeline keeps its stage 5 and last divider stage unchanged.
	`LRP3_ASSERT_NEXT(a_freeze_s5, !adv, $stable(v_s5) && $stable(v_d_q[DIV_STAGES]),
		"pipeline moved during a stall")

endmodule

// ===== bench/lrp3_checker.sv =====
// Checker for the line rotate and project block: tracks register writes,
// predicts each projected line and compares it with the output channel.
// Depends on lrp3_pkg and the channel interfaces in lrp3_if.
module lrp3_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lrp3_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lrp3_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lrp3_in_if                              in_ch,
	lrp3_out_if                             out_ch,
	output int                              errors,
	output int                              pending
);
	import lrp3_pkg::*;

	typedef struct {
		logic signed [SCR_W-1:0] sx0;
		logic signed [SCR_W-1:0] sy0;
		logic signed [SCR_W-1:0] sx1;
		logic signed [SCR_W-1:0] sy1;
		logic                    ok;
	} screen_line_t;

	screen_line_t line_q[$];
	logic [XOFF_W-1:0] x_off;
	logic [YOFF_W-1:0] y_off;
	logic [DOFF_W-1:0] d_off;

	function automatic longint sine_q14(input int deg);
		int d;
		d = deg % 360;
		if (d <= 90) return SIN_TAB[d];
		if (d <= 180) return SIN_TAB[180 - d];
		if (d <= 270) return -longint'(SIN_TAB[d - 180]);
		return -longint'(SIN_TAB[360 - d]);
	endfunction

	function automatic longint shr_toward_zero(input longint v);
		return (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// Rotates and projects one endpoint; returns 0 unless beyond the near plane.
	function automatic bit project_point(input longint m[9], input longint px,
			input longint py, input longint pz, output longint sx, output longint sy);
		longint rx, ry, rz, depth;
		rx = shr_toward_zero(px * m[0] + py * m[1] + pz * m[2]);
		ry = shr_toward_zero(px * m[3] + py * m[4] + pz * m[5]);
		rz = shr_toward_zero(px * m[6] + py * m[7] + pz * m[8]);
		depth = rz - longint'(d_off);
		sx = 0;
		sy = 0;
		if (depth >= -5) return 0;
		sx = clamp16((256 * rx) / depth + longint'(x_off));
		sy = clamp16((256 * ry) / depth + longint'(y_off));
		return 1;
	endfunction

	function automatic screen_line_t predict_line();
		screen_line_t r;
		longint m[9];
		longint s1, c1, s2, c2, ax, ay, bx, by;
		int xa, ya;
		bit ok0, ok1;
		xa = int'(in_ch.x_angle) % 360;
		ya = int'(in_ch.y_angle) % 360;
		s1 = sine_q14(ya);
		c1 = sine_q14(ya + 90);
		s2 = sine_q14(xa);
		c2 = sine_q14(xa + 90);
		m[0] = c1;
		m[1] = 0;
		m[2] = -s1;
		m[3] = shr_toward_zero(s1 * s2);
		m[4] = c2;
		m[5] = shr_toward_zero(c1 * s2);
		m[6] = shr_toward_zero(s1 * c2);
		m[7] = -s2;
		m[8] = shr_toward_zero(c1 * c2);
		ok0 = project_point(m, in_ch.start_x, in_ch.start_y, in_ch.start_z, ax, ay);
		ok1 = project_point(m, in_ch.end_x, in_ch.end_y, in_ch.end_z, bx, by);
		r.ok = ok0 && ok1;
		r.sx0 = r.ok ? SCR_W'(ax) : '0;
		r.sy0 = r.ok ? SCR_W'(ay) : '0;
		r.sx1 = r.ok ? SCR_W'(bx) : '0;
		r.sy1 = r.ok ? SCR_W'(by) : '0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		screen_line_t w;
		if (!arst_n) begin
			x_off <= XOFF_W'(63);
			y_off <= YOFF_W'(63);
			d_off <= DOFF_W'(500);
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				line_q.push_back(predict_line());
			end
			if (out_ch.valid && out_ch.ready) begin
				if (line_q.size() == 0) begin
					report_mismatch("unexpected transaction", out_ch.line_valid, 0);
				end else begin
					w = line_q.pop_front();
					if (out_ch.line_valid !== w.ok)
						report_mismatch("line_valid", out_ch.line_valid, w.ok);
					if (out_ch.screen_start_x !== w.sx0)
						report_mismatch("screen_start_x", out_ch.screen_start_x, w.sx0);
					if (out_ch.screen_start_y !== w.sy0)
						report_mismatch("screen_start_y", out_ch.screen_start_y, w.sy0);
					if (out_ch.screen_end_x !== w.sx1)
						report_mismatch("screen_end_x", out_ch.screen_end_x, w.sx1);
					if (out_ch.screen_end_y !== w.sy1)
						report_mismatch("screen_end_y", out_ch.screen_end_y, w.sy1);
				end
			end
			pending <= line_q.size();
			if (cfg_wr_en) begin
				case (cfg_idx)
					REG_SCREEN_X: x_off <= cfg_wdata[XOFF_W-1:0];
					REG_SCREEN_Y: y_off <= cfg_wdata[YOFF_W-1:0];
					REG_DEPTH:    d_off <= cfg_wdata[DOFF_W-1:0];
					default:      ;
				endcase
			end
		end
	end

	// Anything still waiting at the end is reported by the top through pending.
endmodule

// ===== bench/tb.sv =====
// Top of the line rotate and project testbench: clock, reset, stimulus, register
// writes and the verdict. Depends on lrp3_pkg, lrp3_if, lrp3_checker and the DUT.
module tb;
	import lrp3_pkg::*;

	// Index past the end of the register list; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int errors;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int depth_now = 500;

	lrp3_in_if in_ch();
	lrp3_out_if out_ch();

	line_rotate_project_3d_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
	);

	lrp3_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
		.errors(errors), .pending(pending)
	);

	always #2 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.x_angle = '0;
		in_ch.y_angle = '0;
		in_ch.start_x = '0;
		in_ch.start_y = '0;
		in_ch.start_z = '0;
		in_ch.end_x = '0;
		in_ch.end_y = '0;
		in_ch.end_z = '0;
		out_ch.ready = 1'b0;
	end

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one segment and holds it until the block takes the transaction.
	// Afterwards the sender may go idle, deciding again in every cycle, so that
	// the share of idle cycles matches the current phase.
	task automatic send_line(input int xa, input int ya, input int sx, input int sy,
			input int sz, input int ex, input int ey, input int ez);
		in_ch.x_angle <= ANGLE_W'(xa);
		in_ch.y_angle <= ANGLE_W'(ya);
		in_ch.start_x <= COORD_W'(sx);
		in_ch.start_y <= COORD_W'(sy);
		in_ch.start_z <= COORD_W'(sz);
		in_ch.end_x <= COORD_W'(ex);
		in_ch.end_y <= COORD_W'(ey);
		in_ch.end_z <= COORD_W'(ez);
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Lets the pipeline empty, then waits out the latency so that a register
	// write cannot land on a transaction still in flight.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_DEPTH) depth_now = value;
	endtask

	function automatic int full_coord();
		return int'($urandom_range(4095)) - 2048;
	endfunction

	// Most coordinates are kept within reach of the viewer so that both
	// endpoints land beyond the near plane and the divider does real work;
	// the rest use the full coordinate range, for rejection and saturation.
	task automatic random_lines(input int count);
		int reach;
		int c[6];
		for (int n = 0; n < count; n++) begin
			reach = depth_now / 2;
			if (reach > 2047) reach = 2047;
			for (int k = 0; k < 6; k++) begin
				if (reach >= 8 && $urandom_range(99) < 70)
					c[k] = int'($urandom_range(2 * reach)) - reach;
				else
					c[k] = full_coord();
			end
			send_line($urandom_range(511), $urandom_range(511),
				c[0], c[1], c[2], c[3], c[4], c[5]);
			// Once in a while the sender waits for every result to come back.
			if ($urandom_range(99) == 0) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part with the reset register values: depth offset 500.
		send_line(0, 0, 0, 0, 0, 0, 0, 0);
		send_line(0, 0, 2047, 2047, 2047, -2048, -2048, -2048);
		send_line(0, 0, 100, -100, 494, -100, 100, 494);
		send_line(0, 0, 100, 100, 495, 10, 10, -10);
		send_line(0, 0, 10, 10, -10, 100, 100, 495);
		send_line(0, 0, 2047, -2048, 494, -2048, 2047, 494);
		send_line(90, 0, 50, 60, 70, -50, -60, -70);
		send_line(0, 90, 50, 60, 70, -50, -60, -70);
		send_line(180, 180, 120, -30, 40, -20, 80, -90);
		send_line(270, 270, 120, -30, 40, -20, 80, -90);
		send_line(359, 1, 200, 200, 200, -200, -200, -200);
		send_line(360, 360, 120, -30, 40, -20, 80, -90);
		send_line(511, 511, 120, -30, 40, -20, 80, -90);
		send_line(450, 405, 120, -30, 40, -20, 80, -90);
		send_line(45, 135, -2048, -2048, -2048, 2047, 2047, 2047);
		send_line(225, 315, 0, 0, 2047, 0, 0, -2048);
		send_line(0, 0, -1, -1, -1, 1, 1, 1);
		send_line(30, 60, 2047, 0, -2048, 0, 2047, -2048);
		random_lines(150);
		drain();

		// Sender idles most of the time; offsets at their upper extremes.
		write_reg(REG_SCREEN_X, 1023);
		write_reg(REG_SCREEN_Y, 1023);
		write_reg(REG_DEPTH, 4095);
		write_reg(REG_NONE, 4095);
		idle_pct = 75;
		send_line(0, 0, 2047, -2048, -2048, -2048, 2047, 2047);
		random_lines(160);
		drain();

		// Receiver stalls most of the time; offsets at their lower extremes.
		write_reg(REG_SCREEN_X, 0);
		write_reg(REG_SCREEN_Y, 0);
		write_reg(REG_DEPTH, 0);
		idle_pct = 0;
		stall_pct = 75;
		send_line(0, 0, 2047, -2048, -6, -2048, 2047, -6);
		send_line(0, 0, 5, 5, -5, 5, 5, -6);
		random_lines(160);
		drain();

		// Both sides idle now and then with middle settings.
		write_reg(REG_SCREEN_X, 512);
		write_reg(REG_SCREEN_Y, 300);
		write_reg(REG_DEPTH, 800);
		idle_pct = 12;
		stall_pct = 12;
		random_lines(160);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("** line_rotate_project_3d_unit: PASSED **");
		end else begin
			$display("** line_rotate_project_3d_unit: FAILED **");
		end
		$finish;
	end

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("** line_rotate_project_3d_unit: FAILED **");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/lrp3_pkg.sv
src/lrp3_if.sv
src/lrp3_div.sv
src/line_rotate_project_3d_unit.sv
bench/lrp3_checker.sv
bench/tb.sv
